/* hw/rtl/assert_macros.svh */
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds whenever the antecedent holds, same cycle
`define COF_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// condition holds in the cycle after the antecedent
`define COF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/cof_pkg.sv */
// package: constants, payload types and channel compare helpers for the outline filter
package cof_pkg;

  localparam int MAX_WIDTH = 1024;
  localparam int COL_W     = $clog2(MAX_WIDTH);
  localparam int WID_W     = 11;
  localparam int HGT_W     = 12;
  localparam int CHAN_W    = 8;
  localparam int PIX_W     = 3 * CHAN_W;
  localparam int EMIT_W    = 22;
  localparam int CMPW_W    = (COL_W + 1 > WID_W) ? COL_W + 1 : WID_W;
  localparam int TOT_W     = CMPW_W + HGT_W;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;

  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DARK_LEVEL   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LIGHT_LEVEL  = 2'd3;

  localparam logic [WID_W-1:0]  WIDTH_RESET  = 11'd640;
  localparam logic [HGT_W-1:0]  HEIGHT_RESET = 12'd480;
  localparam logic [CHAN_W-1:0] DARK_RESET   = 8'd85;
  localparam logic [CHAN_W-1:0] LIGHT_RESET  = 8'd170;

  localparam logic [HGT_W-1:0]  ROW_LIMIT = 12'd4095;
  localparam logic [CHAN_W-1:0] CHAN_MAX  = 8'd255;

  typedef logic [PIX_W-1:0] pix_t;

  typedef struct packed {
    logic [CHAN_W-1:0] red_in;
    logic [CHAN_W-1:0] green_in;
    logic [CHAN_W-1:0] blue_in;
    logic              drain;
  } cof_in_t;

  typedef struct packed {
    logic [CHAN_W-1:0] red_out;
    logic [CHAN_W-1:0] green_out;
    logic [CHAN_W-1:0] blue_out;
    logic              frame_end;
  } cof_out_t;

  function automatic logic all_at_least(input pix_t px, input logic [CHAN_W-1:0] level);
    logic r;
    r = 1'b1;
    for (int k = 0; k < 3; k++) begin
      if (px[k*CHAN_W +: CHAN_W] < level) r = 1'b0;
    end
    return r;
  endfunction

  function automatic logic all_at_most(input pix_t px, input logic [CHAN_W-1:0] level);
    logic r;
    r = 1'b1;
    for (int k = 0; k < 3; k++) begin
      if (px[k*CHAN_W +: CHAN_W] > level) r = 1'b0;
    end
    return r;
  endfunction

endpackage

/* hw/rtl/cof_ram.sv */
// generic single-write, single-read ram with registered read data
module cof_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    // read returns the old contents on a same-address write
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

endmodule

/* hw/rtl/contrast_outline_filter_unit.sv */
// top level: 3x3 threshold outline filter over an rgb raster stream
//
// Pixels enter on the in_ channel (valid/ready) in raster order, one
// transaction per pixel; results leave on the out_ channel (valid/ready).
// Each pixel is compared with its eight neighbours: a strongly light centre
// next to a strongly dark neighbour, or the reverse, turns it black, else
// white. Border rows and columns pass through unchanged.
// Results lag the input by one row plus one pixel; after the last pixel of a
// frame, image_width + 1 drain transactions push the remaining results out.
// A drain transaction taken before the frame's pixels are all in is consumed
// with no effect. frame_end marks the last result of a frame.
// Throughput: one transaction per cycle while the output is not stalled. The
// line memory is read at acceptance, the window compare when stage 1 advances.
// The two previous rows sit in one 48-bit wide line memory, read and written
// at the same column each transaction, with forwarding for back-to-back use
// of one column.
// Reset clears counters, window and the pipeline; configuration registers
// return to 640 x 480, dark 85, light 170. Line memory needs no clearing.
// When out_valid is high and out_ready is low the output register holds and
// in_ready drops once the internal stage is full.
`include "assert_macros.svh"

module contrast_outline_filter_unit import cof_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  cof_in_t               in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output cof_out_t              out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  // configuration
  logic [WID_W-1:0]  image_width_r;
  logic [HGT_W-1:0]  image_height_r;
  logic [CHAN_W-1:0] dark_level_r;
  logic [CHAN_W-1:0] light_level_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_width_r  <= WIDTH_RESET;
      image_height_r <= HEIGHT_RESET;
      dark_level_r   <= DARK_RESET;
      light_level_r  <= LIGHT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_IMAGE_WIDTH:  image_width_r  <= cfg_wdata[WID_W-1:0];
        CFG_IMAGE_HEIGHT: image_height_r <= cfg_wdata[HGT_W-1:0];
        CFG_DARK_LEVEL:   dark_level_r   <= cfg_wdata[CHAN_W-1:0];
        CFG_LIGHT_LEVEL:  light_level_r  <= cfg_wdata[CHAN_W-1:0];
        default: ;
      endcase
    end
  end

  logic [CMPW_W-1:0] w_ext;
  logic [CMPW_W-1:0] w_c;
  logic [HGT_W-1:0]  h_c;
  logic [TOT_W-1:0]  total;

  always_comb begin
    w_ext = CMPW_W'(image_width_r);
    if (image_width_r == '0) begin
      w_c = CMPW_W'(1);
    end else if (w_ext > CMPW_W'(MAX_WIDTH)) begin
      w_c = CMPW_W'(MAX_WIDTH);
    end else begin
      w_c = w_ext;
    end
    h_c = (image_height_r == '0) ? HGT_W'(1) : image_height_r;
  end

  // frame size follows the registers at once
  always_comb begin
    total = TOT_W'(w_c) * TOT_W'(h_c);
  end

  // position counters and acceptance decisions
  logic [COL_W-1:0]  col_r;
  logic [HGT_W-1:0]  row_r;
  logic [EMIT_W-1:0] emit_cnt_r;

  logic [CMPW_W-1:0] col_ext;
  logic [CMPW_W-1:0] col_c;
  logic [CMPW_W-1:0] col_inc;
  logic [COL_W-1:0]  col_addr;
  logic [TOT_W-1:0]  emit_inc;
  logic              beyond;
  logic              noop;
  logic              row_end;
  logic              emit;
  logic              interior;
  logic              last;
  logic              accept;
  logic              take;

  always_comb begin
    col_ext  = CMPW_W'(col_r);
    col_c    = (col_ext >= w_c) ? w_c - CMPW_W'(1) : col_ext;
    col_inc  = col_c + CMPW_W'(1);
    col_addr = col_c[COL_W-1:0];
    beyond   = row_r >= h_c;
    noop     = in_data.drain && !beyond;
    row_end  = col_inc >= w_c;
    emit     = (row_r >= HGT_W'(2)) || (row_r == HGT_W'(1) && col_c >= CMPW_W'(1));
    interior = (col_c >= CMPW_W'(2)) && (row_r >= HGT_W'(2)) && (row_r <= h_c - HGT_W'(1));
    emit_inc = TOT_W'(emit_cnt_r) + TOT_W'(1);
    last     = emit_inc >= total;
  end

  assign accept = in_valid && in_ready;
  assign take   = accept && !noop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r      <= '0;
      row_r      <= '0;
      emit_cnt_r <= '0;
    end else if (take) begin
      if (emit && last) begin
        col_r      <= '0;
        row_r      <= '0;
        emit_cnt_r <= '0;
      end else begin
        if (row_end) begin
          col_r <= '0;
          row_r <= (row_r < ROW_LIMIT) ? row_r + HGT_W'(1) : ROW_LIMIT;
        end else begin
          col_r <= col_inc[COL_W-1:0];
        end
        if (emit) begin
          emit_cnt_r <= emit_inc[EMIT_W-1:0];
        end
      end
    end
  end

  // stage 1: line memory read in flight
  logic             s1_valid_r;
  logic             s1_emit_r;
  logic             s1_interior_r;
  logic             s1_last_r;
  logic [COL_W-1:0] s1_addr_r;
  pix_t             s1_px_r;
  logic             fwd_r;
  pix_t             wr_up_r;
  pix_t             wr_mid_r;
  logic             s1_adv;
  logic             out_valid_r;
  cof_out_t         out_data_r;

  assign s1_adv   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      fwd_r      <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= take;
      // the column written at this edge is read stale by the ram
      fwd_r      <= take && s1_adv && (s1_addr_r == col_addr);
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_emit_r     <= emit;
      s1_interior_r <= interior;
      s1_last_r     <= last;
      s1_addr_r     <= col_addr;
      s1_px_r       <= in_data.drain ? '0 :
                       {in_data.red_in, in_data.green_in, in_data.blue_in};
    end
  end

  // line memory: upper row in the top half, middle row in the bottom half
  logic [2*PIX_W-1:0] line_rdata;
  pix_t               up_cur;
  pix_t               mid_cur;

  assign up_cur  = fwd_r ? wr_up_r  : line_rdata[2*PIX_W-1:PIX_W];
  assign mid_cur = fwd_r ? wr_mid_r : line_rdata[PIX_W-1:0];

  cof_ram #(
    .WIDTH (2 * PIX_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk     (clk),
    .we      (s1_adv),
    .waddr   (s1_addr_r),
    .wdata   ({mid_cur, s1_px_r}),
    .re      (take),
    .raddr   (col_addr),
    .rdata_r (line_rdata)
  );

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      wr_up_r  <= mid_cur;
      wr_mid_r <= s1_px_r;
    end
  end

  // 3x3 window, column 2 is the newest
  pix_t win_r [9];
  pix_t win_nxt [9];
  pix_t nb [8];
  pix_t centre;
  pix_t res;
  logic centre_light;
  logic centre_dark;
  logic hit;

  always_comb begin
    win_nxt[0] = win_r[1];
    win_nxt[1] = win_r[2];
    win_nxt[2] = up_cur;
    win_nxt[3] = win_r[4];
    win_nxt[4] = win_r[5];
    win_nxt[5] = mid_cur;
    win_nxt[6] = win_r[7];
    win_nxt[7] = win_r[8];
    win_nxt[8] = s1_px_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 9; i++) begin
        win_r[i] <= '0;
      end
    end else if (s1_adv) begin
      for (int i = 0; i < 9; i++) begin
        win_r[i] <= win_nxt[i];
      end
    end
  end

  always_comb begin
    centre = win_nxt[4];
    nb[0]  = win_nxt[0];
    nb[1]  = win_nxt[1];
    nb[2]  = win_nxt[2];
    nb[3]  = win_nxt[3];
    nb[4]  = win_nxt[5];
    nb[5]  = win_nxt[6];
    nb[6]  = win_nxt[7];
    nb[7]  = win_nxt[8];
    centre_light = all_at_least(centre, light_level_r);
    centre_dark  = all_at_most(centre, dark_level_r);
    hit = 1'b0;
    for (int i = 0; i < 8; i++) begin
      if ((centre_light && all_at_most(nb[i], dark_level_r)) ||
          (centre_dark && all_at_least(nb[i], light_level_r))) begin
        hit = 1'b1;
      end
    end
    if (s1_interior_r) begin
      res = hit ? '0 : {CHAN_MAX, CHAN_MAX, CHAN_MAX};
    end else begin
      res = centre;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= s1_emit_r;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_emit_r) begin
      out_data_r.red_out   <= res[3*CHAN_W-1:2*CHAN_W];
      out_data_r.green_out <= res[2*CHAN_W-1:CHAN_W];
      out_data_r.blue_out  <= res[CHAN_W-1:0];
      out_data_r.frame_end <= s1_last_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // assertions
  `COF_ASSERT_IMPL(a_fwd_needs_stage, fwd_r, s1_valid_r, "forward flag without a stage 1 transaction")
  `COF_ASSERT_NEXT(a_stage_holds, s1_valid_r && out_valid_r && !out_ready, s1_valid_r && $stable(s1_addr_r), "stage 1 lost while output stalled")
  `COF_ASSERT_IMPL(a_last_clears_count, s1_valid_r && s1_emit_r && s1_last_r, emit_cnt_r == '0, "result count not cleared at frame end")
  `COF_ASSERT_IMPL(a_out_from_stage, $rose(out_valid_r), $past(s1_valid_r), "output loaded without a stage 1 transaction")

endmodule
